// ----- src/quadratic_extension_field_alu_top_defines.svh -----
// ---------------------------------------------------------------------------
// Quadratic extension field ALU assertion macros
// Shared concurrent assertion forms for the block's RTL.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_EXTENSION_FIELD_ALU_TOP_DEFINES_SVH
`define QUADRATIC_EXTENSION_FIELD_ALU_TOP_DEFINES_SVH

// same-cycle implication
`define QEFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// next-cycle implication
`define QEFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ----- src/qefa_pkg.sv -----
// ---------------------------------------------------------------------------
// Quadratic extension field ALU package
// Shared constants, operation codes, sequencer states and status types.
// ---------------------------------------------------------------------------
package qefa_pkg;

  localparam int MODULUS_BITS_DEF = 30;
  localparam int EXP_BITS = 63;

  localparam logic [63:0] MODULUS_RESET = 64'd999999893;
  localparam logic [63:0] ROOT_SQUARE_RESET = 64'd2;

  localparam logic [0:0] CFG_MODULUS = 1'b0;
  localparam logic [0:0] CFG_ROOT_SQUARE = 1'b1;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIVE  = 4'd3,
    OP_DIVS  = 4'd4,
    OP_POW   = 4'd5,
    OP_NORM  = 4'd6,
    OP_CONJ  = 4'd7,
    OP_EQUAL = 4'd8
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_RD, S_RE, S_DISP,
    S_EM1, S_EM2, S_EM3, S_EM4, S_EM5,
    S_NM1, S_NM2, S_NM3, S_RET,
    S_PW_CHK, S_PW_SQ, S_SP_CHK, S_SP_ACC, S_SP_SQ,
    S_SC1, S_SC2, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    RET_MUL, RET_DIV_NORM, RET_DIV_MUL, RET_INV, RET_POW_R, RET_POW_B, RET_NORM
  } ret_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

// ----- src/qefa_in_if.sv -----
// ---------------------------------------------------------------------------
// Quadratic extension field ALU input channel
// Valid/ready channel carrying one operation item.
// ---------------------------------------------------------------------------
interface qefa_in_if #(
  parameter int N = qefa_pkg::MODULUS_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [3:0]                    operation;
  logic [N-1:0]                  a_real;
  logic [N-1:0]                  a_imag;
  logic [N-1:0]                  b_real;
  logic [N-1:0]                  b_imag;
  logic [qefa_pkg::EXP_BITS-1:0] exponent;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, exponent,
                  input ready);
  modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, exponent,
                output ready);
endinterface

// ----- src/qefa_out_if.sv -----
// ---------------------------------------------------------------------------
// Quadratic extension field ALU output channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface qefa_out_if #(
  parameter int N = qefa_pkg::MODULUS_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [N-1:0] result_real;
  logic [N-1:0] result_imag;
  logic         equal_flag;

  modport source (output valid, result_real, result_imag, equal_flag, input ready);
  modport sink (input valid, result_real, result_imag, equal_flag, output ready);
endinterface

// ----- src/quadratic_extension_field_alu_top.sv -----
// ---------------------------------------------------------------------------
// Quadratic extension field ALU
// Arithmetic over re + im*sqrt(d) modulo a configurable prime p.
// ---------------------------------------------------------------------------
// Usage:
//   item_in carries operation, two elements and an exponent; item_out returns
//   result_real, result_imag and equal_flag. Both are valid/ready channels.
//   The user must write modulus and root_square through cfg_we/cfg_index/
//   cfg_data only while no item is in flight; the block does not enforce it.
//   One item is processed at a time; item_in.ready is high only when idle.
//   Every modular product runs on one bit-serial multiplier. Operand
//   reduction costs 5 products. Add, sub, conj and compare then need no
//   further product, mul takes 5 products, norm 3, divide by scalar up
//   to 2*MODULUS_BITS + 2, divide by element about 2*MODULUS_BITS + 10,
//   and power up to 10 products per exponent bit up to its highest set bit.
//   The result stays on item_out until taken; a stalled receiver holds the
//   block. Reset restores modulus 999999893 and root_square 2 and empties it.
// ---------------------------------------------------------------------------
`include "quadratic_extension_field_alu_top_defines.svh"

module quadratic_extension_field_alu_top #(
  parameter int MODULUS_BITS = qefa_pkg::MODULUS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [MODULUS_BITS-1:0] cfg_data,
  qefa_in_if.sink                 item_in,
  qefa_out_if.source              item_out
);

  localparam int N = MODULUS_BITS;
  localparam int EW = qefa_pkg::EXP_BITS;

  qefa_pkg::state_t   state;
  qefa_pkg::state_t   state_next;
  qefa_pkg::ret_t     ret;
  qefa_pkg::op_t      op;
  qefa_pkg::mul_sts_t mul_sts;

  logic [N-1:0]  modulus;
  logic [N-1:0]  root_square;
  logic [N-1:0]  p_item;
  logic [N-1:0]  one;
  logic [N-1:0]  pm2;
  logic [EW-1:0] expo;
  logic [N-1:0]  ar, ai, br, bi, dd, t1, t2;
  logic [N-1:0]  xr, xi, yr, yi, zr, zi;
  logic [N-1:0]  cur, acc, rr, ri;
  logic          eq;
  logic          issued;
  logic          mul_state;
  logic          mul_start;
  logic [N-1:0]  mul_x;
  logic [N-1:0]  mul_y;
  logic [N-1:0]  mul_z;
  logic          mul_done;

  function automatic logic [N-1:0] addm(input logic [N-1:0] u, input logic [N-1:0] v,
                                        input logic [N-1:0] pm);
    logic [N:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, pm}) s = s - {1'b0, pm};
    return s[N-1:0];
  endfunction

  function automatic logic [N-1:0] subm(input logic [N-1:0] u, input logic [N-1:0] v,
                                        input logic [N-1:0] pm);
    logic [N:0] s;
    s = {1'b0, u} + {1'b0, pm} - {1'b0, v};
    if (s >= {1'b0, pm}) s = s - {1'b0, pm};
    return s[N-1:0];
  endfunction

  assign one = (p_item == N'(1)) ? '0 : N'(1);
  assign pm2 = (p_item >= N'(2)) ? p_item - N'(2) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= N'(qefa_pkg::MODULUS_RESET);
      root_square <= N'(qefa_pkg::ROOT_SQUARE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        qefa_pkg::CFG_MODULUS:     modulus <= cfg_data;
        qefa_pkg::CFG_ROOT_SQUARE: root_square <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_state = 1'b1;
    mul_x = '0;
    mul_y = '0;
    case (state)
      qefa_pkg::S_RA:     begin mul_x = one; mul_y = ar; end
      qefa_pkg::S_RB:     begin mul_x = one; mul_y = ai; end
      qefa_pkg::S_RC:     begin mul_x = one; mul_y = br; end
      qefa_pkg::S_RD:     begin mul_x = one; mul_y = bi; end
      qefa_pkg::S_RE:     begin mul_x = one; mul_y = root_square; end
      qefa_pkg::S_EM1:    begin mul_x = dd; mul_y = xi; end
      qefa_pkg::S_EM2:    begin mul_x = t1; mul_y = yi; end
      qefa_pkg::S_EM3:    begin mul_x = xr; mul_y = yr; end
      qefa_pkg::S_EM4:    begin mul_x = xr; mul_y = yi; end
      qefa_pkg::S_EM5:    begin mul_x = xi; mul_y = yr; end
      qefa_pkg::S_NM1:    begin mul_x = dd; mul_y = xi; end
      qefa_pkg::S_NM2:    begin mul_x = t1; mul_y = xi; end
      qefa_pkg::S_NM3:    begin mul_x = xr; mul_y = xr; end
      qefa_pkg::S_SP_ACC: begin mul_x = acc; mul_y = cur; end
      qefa_pkg::S_SP_SQ:  begin mul_x = cur; mul_y = cur; end
      qefa_pkg::S_SC1:    begin mul_x = acc; mul_y = zr; end
      qefa_pkg::S_SC2:    begin mul_x = acc; mul_y = zi; end
      default:            mul_state = 1'b0;
    endcase
  end

  assign mul_start = mul_state && !issued;
  assign mul_done = mul_sts.done;

  qefa_mulm #(.N(N)) u_mulm (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .p     (p_item),
    .sts   (mul_sts),
    .z     (mul_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qefa_pkg::S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) issued <= 1'b1;
      else if (mul_done) issued <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qefa_pkg::S_IDLE: if (item_in.valid) state_next = qefa_pkg::S_RA;
      qefa_pkg::S_RA:   if (mul_done) state_next = qefa_pkg::S_RB;
      qefa_pkg::S_RB:   if (mul_done) state_next = qefa_pkg::S_RC;
      qefa_pkg::S_RC:   if (mul_done) state_next = qefa_pkg::S_RD;
      qefa_pkg::S_RD:   if (mul_done) state_next = qefa_pkg::S_RE;
      qefa_pkg::S_RE:   if (mul_done) state_next = qefa_pkg::S_DISP;
      qefa_pkg::S_DISP: begin
        case (op)
          qefa_pkg::OP_MUL:  state_next = qefa_pkg::S_EM1;
          qefa_pkg::OP_DIVE,
          qefa_pkg::OP_NORM: state_next = qefa_pkg::S_NM1;
          qefa_pkg::OP_DIVS: state_next = qefa_pkg::S_SP_CHK;
          qefa_pkg::OP_POW:  state_next = qefa_pkg::S_PW_CHK;
          default:           state_next = qefa_pkg::S_OUT;
        endcase
      end
      qefa_pkg::S_EM1: if (mul_done) state_next = qefa_pkg::S_EM2;
      qefa_pkg::S_EM2: if (mul_done) state_next = qefa_pkg::S_EM3;
      qefa_pkg::S_EM3: if (mul_done) state_next = qefa_pkg::S_EM4;
      qefa_pkg::S_EM4: if (mul_done) state_next = qefa_pkg::S_EM5;
      qefa_pkg::S_EM5: if (mul_done) state_next = qefa_pkg::S_RET;
      qefa_pkg::S_NM1: if (mul_done) state_next = qefa_pkg::S_NM2;
      qefa_pkg::S_NM2: if (mul_done) state_next = qefa_pkg::S_NM3;
      qefa_pkg::S_NM3: if (mul_done) state_next = qefa_pkg::S_RET;
      qefa_pkg::S_RET: begin
        unique case (ret)
          qefa_pkg::RET_DIV_NORM: state_next = qefa_pkg::S_EM1;
          qefa_pkg::RET_DIV_MUL:  state_next = qefa_pkg::S_SP_CHK;
          qefa_pkg::RET_INV:      state_next = qefa_pkg::S_SC1;
          qefa_pkg::RET_POW_R:    state_next = qefa_pkg::S_PW_SQ;
          qefa_pkg::RET_POW_B:    state_next = qefa_pkg::S_PW_CHK;
          default:                state_next = qefa_pkg::S_OUT;
        endcase
      end
      qefa_pkg::S_PW_CHK: begin
        if (expo == '0) state_next = qefa_pkg::S_OUT;
        else if (expo[0]) state_next = qefa_pkg::S_EM1;
        else state_next = qefa_pkg::S_PW_SQ;
      end
      qefa_pkg::S_PW_SQ: state_next = qefa_pkg::S_EM1;
      qefa_pkg::S_SP_CHK: begin
        if (expo == '0) state_next = qefa_pkg::S_RET;
        else if (expo[0]) state_next = qefa_pkg::S_SP_ACC;
        else state_next = qefa_pkg::S_SP_SQ;
      end
      qefa_pkg::S_SP_ACC: if (mul_done) state_next = qefa_pkg::S_SP_SQ;
      qefa_pkg::S_SP_SQ:  if (mul_done) state_next = qefa_pkg::S_SP_CHK;
      qefa_pkg::S_SC1:    if (mul_done) state_next = qefa_pkg::S_SC2;
      qefa_pkg::S_SC2:    if (mul_done) state_next = qefa_pkg::S_OUT;
      qefa_pkg::S_OUT:    if (item_out.ready) state_next = qefa_pkg::S_IDLE;
      default:            state_next = qefa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      qefa_pkg::S_IDLE: begin
        if (item_in.valid) begin
          op <= qefa_pkg::op_t'(item_in.operation);
          ar <= item_in.a_real;
          ai <= item_in.a_imag;
          br <= item_in.b_real;
          bi <= item_in.b_imag;
          expo <= item_in.exponent;
          p_item <= (modulus < N'(2)) ? N'(1) : modulus;
        end
      end
      qefa_pkg::S_RA: if (mul_done) ar <= mul_z;
      qefa_pkg::S_RB: if (mul_done) ai <= mul_z;
      qefa_pkg::S_RC: if (mul_done) br <= mul_z;
      qefa_pkg::S_RD: if (mul_done) bi <= mul_z;
      qefa_pkg::S_RE: if (mul_done) dd <= mul_z;
      qefa_pkg::S_DISP: begin
        case (op)
          qefa_pkg::OP_ADD: begin
            eq <= 1'b0;
            rr <= addm(ar, br, p_item);
            ri <= addm(ai, bi, p_item);
          end
          qefa_pkg::OP_SUB: begin
            eq <= 1'b0;
            rr <= subm(ar, br, p_item);
            ri <= subm(ai, bi, p_item);
          end
          qefa_pkg::OP_MUL: begin
            eq <= 1'b0;
            xr <= ar; xi <= ai; yr <= br; yi <= bi;
            ret <= qefa_pkg::RET_MUL;
          end
          qefa_pkg::OP_DIVE: begin
            eq <= 1'b0;
            xr <= br; xi <= bi;
            ret <= qefa_pkg::RET_DIV_NORM;
          end
          qefa_pkg::OP_DIVS: begin
            eq <= 1'b0;
            zr <= ar; zi <= ai; cur <= br; acc <= one;
            expo <= EW'(pm2);
            ret <= qefa_pkg::RET_INV;
          end
          qefa_pkg::OP_POW: begin
            eq <= 1'b0;
            rr <= one;
            ri <= '0;
          end
          qefa_pkg::OP_NORM: begin
            eq <= 1'b0;
            xr <= ar; xi <= ai;
            ret <= qefa_pkg::RET_NORM;
          end
          qefa_pkg::OP_CONJ: begin
            eq <= 1'b0;
            rr <= ar;
            ri <= subm('0, ai, p_item);
          end
          qefa_pkg::OP_EQUAL: begin
            eq <= (ar == br) && (ai == bi);
            rr <= '0;
            ri <= '0;
          end
          default: begin
            eq <= 1'b0;
            rr <= '0;
            ri <= '0;
          end
        endcase
      end
      qefa_pkg::S_EM1: if (mul_done) t1 <= mul_z;
      qefa_pkg::S_EM2: if (mul_done) t1 <= mul_z;
      qefa_pkg::S_EM3: if (mul_done) zr <= addm(mul_z, t1, p_item);
      qefa_pkg::S_EM4: if (mul_done) t1 <= mul_z;
      qefa_pkg::S_EM5: if (mul_done) zi <= addm(t1, mul_z, p_item);
      qefa_pkg::S_NM1: if (mul_done) t1 <= mul_z;
      qefa_pkg::S_NM2: if (mul_done) t1 <= mul_z;
      qefa_pkg::S_NM3: if (mul_done) t2 <= subm(mul_z, t1, p_item);
      qefa_pkg::S_RET: begin
        case (ret)
          qefa_pkg::RET_MUL, qefa_pkg::RET_POW_R: begin
            rr <= zr; ri <= zi;
          end
          qefa_pkg::RET_DIV_NORM: begin
            cur <= t2;
            xr <= ar; xi <= ai; yr <= br;
            yi <= subm('0, bi, p_item);
            ret <= qefa_pkg::RET_DIV_MUL;
          end
          qefa_pkg::RET_DIV_MUL: begin
            acc <= one;
            expo <= EW'(pm2);
            ret <= qefa_pkg::RET_INV;
          end
          qefa_pkg::RET_POW_B: begin
            ar <= zr; ai <= zi;
            expo <= expo >> 1;
          end
          qefa_pkg::RET_NORM: begin
            rr <= t2; ri <= '0;
          end
          default: ;
        endcase
      end
      qefa_pkg::S_PW_CHK: begin
        if (expo != '0 && expo[0]) begin
          xr <= ar; xi <= ai; yr <= rr; yi <= ri;
          ret <= qefa_pkg::RET_POW_R;
        end
      end
      qefa_pkg::S_PW_SQ: begin
        xr <= ar; xi <= ai; yr <= ar; yi <= ai;
        ret <= qefa_pkg::RET_POW_B;
      end
      qefa_pkg::S_SP_ACC: if (mul_done) acc <= mul_z;
      qefa_pkg::S_SP_SQ: begin
        if (mul_done) begin
          cur <= mul_z;
          expo <= expo >> 1;
        end
      end
      qefa_pkg::S_SC1: if (mul_done) rr <= mul_z;
      qefa_pkg::S_SC2: if (mul_done) ri <= mul_z;
      default: ;
    endcase
  end

  assign item_in.ready = (state == qefa_pkg::S_IDLE);
  assign item_out.valid = (state == qefa_pkg::S_OUT);
  assign item_out.result_real = rr;
  assign item_out.result_imag = ri;
  assign item_out.equal_flag = eq;

  `QEFA_ASSERT_IMP(a_start_idle, clk, rst, mul_start, !mul_sts.busy)
  `QEFA_ASSERT_IMP(a_done_issued, clk, rst, mul_done, issued)
  `QEFA_ASSERT_NEXT(a_accept_reduce, clk, rst, item_in.valid && item_in.ready, state == qefa_pkg::S_RA)
  `QEFA_ASSERT_IMP(a_out_reduced, clk, rst, item_out.valid, (rr < p_item) && (ri < p_item))
  `QEFA_ASSERT_IMP(a_flag_zero, clk, rst, item_out.valid && eq, (rr == '0) && (ri == '0))

endmodule

// ----- src/qefa_mulm.sv -----
// ---------------------------------------------------------------------------
// Quadratic extension field ALU modular multiplier
// Bit-serial (x * y) mod p, one bit of y per cycle, MSB first; x below p.
// ---------------------------------------------------------------------------
module qefa_mulm #(
  parameter int N = qefa_pkg::MODULUS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [N-1:0]       x,
  input  logic [N-1:0]       y,
  input  logic [N-1:0]       p,
  output qefa_pkg::mul_sts_t sts,
  output logic [N-1:0]       z
);

  localparam int CW = $clog2(N + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [N-1:0]  xq;
  logic [N-1:0]  yq;
  logic [N-1:0]  pq;
  logic [N-1:0]  acc;
  logic [N-1:0]  acc_next;
  logic [N:0]    dbl;
  logic [N:0]    red1;
  logic [N:0]    sum;
  logic [N:0]    red2;

  always_comb begin
    dbl = {acc, 1'b0};
    red1 = (dbl >= {1'b0, pq}) ? dbl - {1'b0, pq} : dbl;
    sum = red1 + (yq[N-1] ? {1'b0, xq} : '0);
    red2 = (sum >= {1'b0, pq}) ? sum - {1'b0, pq} : sum;
    acc_next = red2[N-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc <= '0;
        cnt <= CW'(N);
        xq <= x;
        yq <= y;
        pq <= p;
      end else if (busy) begin
        acc <= acc_next;
        yq <= {yq[N-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign z = acc;

endmodule
